@@ sv/float_calculator_alu_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef FLOAT_CALCULATOR_ALU_CORE_DEFINES_SVH
`define FLOAT_CALCULATOR_ALU_CORE_DEFINES_SVH

// Property on an explicit clock and active-low reset.
`define FCA_ASSERT_AT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Property on the local clk / rst_n.
`define FCA_ASSERT(lbl, prop, msg) `FCA_ASSERT_AT(lbl, clk, rst_n, prop, msg)

`endif

@@ sv/fca_pkg.sv @@
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants of the single-precision calculator ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fca_pkg;

  // Largest accepted |exponent| of the power operation.
  localparam int MAX_EXP    = 64;
  localparam int CNT_W      = $clog2(MAX_EXP + 1);
  // Largest unbiased exponent of an exponent operand that can still pass.
  localparam int PWR_SH_MAX = 10;
  localparam int IVAL_W     = PWR_SH_MAX + 1;

  // Front-to-back queue (power of two).
  localparam int QDEPTH     = 2;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  // Items that can be in flight: queue, back end, output register.
  localparam int MAX_PEND   = QDEPTH + 2;

  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_DEF_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QBIT    = 32'h0040_0000;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_POW = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } fca_op_t;

  typedef enum logic [1:0] {
    K_ARITH  = 2'd0,
    K_POWER  = 2'd1,
    K_DIRECT = 2'd2
  } fca_kind_t;

  typedef struct packed {
    fca_kind_t        kind;
    fca_op_t          op;
    logic [31:0]      opa;
    logic [31:0]      opb;
    logic [CNT_W-1:0] cnt;
    logic             neg;
    logic [31:0]      dval;
    logic             dstat;
  } fca_item_t;

endpackage

`default_nettype wire

@@ sv/fca_if.sv @@
// ----------------------------------------------------------------------------
// fca_in_if / fca_out_if
// Valid/ready channels of the calculator ALU.
// ----------------------------------------------------------------------------
`default_nettype none

interface fca_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input cmd, input operand_a, input operand_b,
                output ready);
endinterface

interface fca_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

@@ sv/fca_front.sv @@
// ----------------------------------------------------------------------------
// fca_front
// Decodes the command and screens the power exponent before queuing.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_front import fca_pkg::*; (
  fca_in_if.sink     in_chan,
  output logic       push_valid,
  input  logic       push_ready,
  output fca_item_t  push_item
);

  logic [7:0]        be;
  logic [23:0]       full;
  logic [7:0]        sh8;
  logic [3:0]        sh;
  logic [IVAL_W-1:0] ival;
  logic [23:0]       fmask;
  logic              zero_b;
  logic              in_range;
  logic              ok_pwr;

  assign push_valid    = in_chan.valid;
  assign in_chan.ready = push_ready;

  always_comb begin
    be       = in_chan.operand_b[30:23];
    full     = {1'b1, in_chan.operand_b[22:0]};
    sh8      = be - 8'd127;
    sh       = sh8[3:0];
    ival     = IVAL_W'(full >> (5'd23 - {1'b0, sh}));
    fmask    = (24'h1 << (5'd23 - {1'b0, sh})) - 24'h1;
    zero_b   = ~|in_chan.operand_b[30:0];
    in_range = (be >= 8'd127) && (be <= 8'(127 + PWR_SH_MAX));
    // exponent must be a whole number no larger than the bound
    ok_pwr   = zero_b ||
               (in_range && ((full & fmask) == 24'h0) && (ival <= IVAL_W'(MAX_EXP)));

    push_item       = '0;
    push_item.kind  = K_DIRECT;
    push_item.op    = OP_ADD;
    push_item.opa   = in_chan.operand_a;
    push_item.opb   = in_chan.operand_b;
    case (in_chan.cmd)
      CMD_ADD: begin
        push_item.kind = K_ARITH;
        push_item.op   = OP_ADD;
      end
      CMD_SUB: begin
        push_item.kind = K_ARITH;
        push_item.op   = OP_SUB;
      end
      CMD_MUL: begin
        push_item.kind = K_ARITH;
        push_item.op   = OP_MUL;
      end
      CMD_DIV: begin
        push_item.kind = K_ARITH;
        push_item.op   = OP_DIV;
      end
      CMD_POW: begin
        if (ok_pwr) begin
          push_item.kind = K_POWER;
          push_item.cnt  = zero_b ? '0 : ival[CNT_W-1:0];
          push_item.neg  = in_chan.operand_b[31] & ~zero_b;
        end else begin
          push_item.dstat = 1'b1;
        end
      end
      default: begin
        push_item.kind = K_DIRECT;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/fca_queue.sv @@
// ----------------------------------------------------------------------------
// fca_queue
// Short FIFO between the classifier and the execution sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_queue import fca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  fca_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output fca_item_t pop_item
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  fca_item_t         mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ sv/fca_back.sv @@
// ----------------------------------------------------------------------------
// fca_back
// Execution sequencer: shared add, multiply, radix-2 divide, normalize and
// round-to-nearest-even steps; iterates multiplies for the power operation.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_back import fca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  fca_item_t pop_item,
  fca_out_if.source out_chan
);

  localparam int DIV_BITS = 26;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_PWR   = 12'b0000_0000_0010,
    S_START = 12'b0000_0000_0100,
    S_ALIGN = 12'b0000_0000_1000,
    S_ADD   = 12'b0000_0001_0000,
    S_MUL   = 12'b0000_0010_0000,
    S_DIVN  = 12'b0000_0100_0000,
    S_DIV   = 12'b0000_1000_0000,
    S_NORM  = 12'b0001_0000_0000,
    S_DEN   = 12'b0010_0000_0000,
    S_RND   = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } back_state_t;

  function automatic logic is_nan(logic [31:0] f);
    return (&f[30:23]) && (|f[22:0]);
  endfunction

  function automatic logic is_inf(logic [31:0] f);
    return (&f[30:23]) && ~(|f[22:0]);
  endfunction

  function automatic logic is_zero(logic [31:0] f);
    return ~(|f[30:0]);
  endfunction

  function automatic logic [7:0] exp_eff(logic [31:0] f);
    return (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
  endfunction

  function automatic logic [23:0] sig24(logic [31:0] f);
    return {(f[30:23] != 8'd0), f[22:0]};
  endfunction

  function automatic logic [4:0] lzc24(logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc49(logic [48:0] v);
    logic [5:0] n;
    n = 6'd49;
    for (int i = 0; i < 49; i++) begin
      if (v[i]) n = 6'(48 - i);
    end
    return n;
  endfunction

  // NaN, infinity, division-by-zero and invalid cases; MSB set when the result is decided here.
  function automatic logic [32:0] fp_special(fca_op_t op, logic [31:0] x,
                                             logic [31:0] y);
    logic [31:0] yb;
    logic        sp;
    logic [32:0] r;
    yb = y;
    if (op == OP_SUB) yb[31] = ~y[31];
    sp = x[31] ^ y[31];
    r  = '0;
    if (is_nan(x)) begin
      r = {1'b1, x | FP_QBIT};
    end else if (is_nan(y)) begin
      r = {1'b1, y | FP_QBIT};
    end else begin
      case (op)
        OP_ADD, OP_SUB: begin
          if (is_inf(x) && is_inf(yb) && (x[31] != yb[31])) r = {1'b1, FP_DEF_NAN};
          else if (is_inf(x)) r = {1'b1, x};
          else if (is_inf(yb)) r = {1'b1, yb};
        end
        OP_MUL: begin
          if ((is_inf(x) && is_zero(y)) || (is_zero(x) && is_inf(y))) begin
            r = {1'b1, FP_DEF_NAN};
          end else if (is_inf(x) || is_inf(y)) begin
            r = {1'b1, sp, 8'hFF, 23'h0};
          end
        end
        OP_DIV: begin
          if ((is_inf(x) && is_inf(y)) || (is_zero(x) && is_zero(y))) begin
            r = {1'b1, FP_DEF_NAN};
          end else if (is_inf(x)) begin
            r = {1'b1, sp, 8'hFF, 23'h0};
          end else if (is_inf(y)) begin
            r = {1'b1, sp, 31'h0};
          end else if (is_zero(y)) begin
            r = {1'b1, sp, 8'hFF, 23'h0};
          end
        end
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  back_state_t       state_r, state_nxt;
  logic              pwr_r, pwr_nxt;
  fca_op_t           op_r, op_nxt;
  logic [31:0]       x_r, x_nxt, y_r, y_nxt, base_r, base_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [31:0]       res_r, res_nxt;
  logic              stat_r, stat_nxt;
  logic              rs_r, rs_nxt, zs_r, zs_nxt, sub_r, sub_nxt;
  logic signed [11:0] re_r, re_nxt;
  logic [49:0]       rm_r, rm_nxt, sm_r, sm_nxt;
  logic              zf_r, zf_nxt, ovf_r, ovf_nxt;
  logic [7:0]        pe_r, pe_nxt;
  logic [22:0]       pf_r, pf_nxt;
  logic              g_r, g_nxt, st_r, st_nxt;
  logic [DIV_BITS-1:0] dq_r, dq_nxt;
  logic [24:0]       drem_r, drem_nxt;
  logic [23:0]       dd_r, dd_nxt;
  logic [4:0]        dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_val_r, out_val_nxt;
  logic              out_stat_r, out_stat_nxt;

  // datapath temporaries
  logic [32:0]       spc;
  logic [31:0]       yb, lop, sop;
  logic              a_big;
  logic [7:0]        el, es, dsh;
  logic [49:0]       small0, smask, sum;
  logic [47:0]       prod;
  logic [4:0]        lza, lzb;
  logic              ge;
  logic [24:0]       diff;
  logic [DIV_BITS-1:0] nq;
  logic [5:0]        lz;
  logic [11:0]       dsh12;
  logic [49:0]       dm, dmask;
  logic              inc;

  assign pop_ready           = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_val_r;
  assign out_chan.status       = out_stat_r;

  always_comb begin
    state_nxt = state_r;
    pwr_nxt   = pwr_r;
    op_nxt    = op_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    rs_nxt    = rs_r;
    zs_nxt    = zs_r;
    sub_nxt   = sub_r;
    re_nxt    = re_r;
    rm_nxt    = rm_r;
    sm_nxt    = sm_r;
    zf_nxt    = zf_r;
    ovf_nxt   = ovf_r;
    pe_nxt    = pe_r;
    pf_nxt    = pf_r;
    g_nxt     = g_r;
    st_nxt    = st_r;
    dq_nxt    = dq_r;
    drem_nxt  = drem_r;
    dd_nxt    = dd_r;
    dcnt_nxt  = dcnt_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;

    spc    = fp_special(op_r, x_r, y_r);
    yb     = {y_r[31] ^ (op_r == OP_SUB), y_r[30:0]};
    a_big  = (x_r[30:0] >= y_r[30:0]);
    lop    = a_big ? x_r : yb;
    sop    = a_big ? yb : x_r;
    el     = exp_eff(lop);
    es     = exp_eff(sop);
    dsh    = el - es;
    small0 = {1'b0, sig24(sop), 25'h0};
    smask  = ~({50{1'b1}} << dsh);
    sum    = sub_r ? rm_r - sm_r : rm_r + sm_r;
    prod   = sig24(x_r) * sig24(y_r);
    lza    = lzc24(sig24(x_r));
    lzb    = lzc24(sig24(y_r));
    ge     = (drem_r >= {1'b0, dd_r});
    diff   = ge ? drem_r - {1'b0, dd_r} : drem_r;
    nq     = {dq_r[DIV_BITS-2:0], ge};
    lz     = lzc49(rm_r[48:0]);
    dsh12  = 12'd1 - re_r;
    dm     = rm_r >> dsh12;
    dmask  = ~({50{1'b1}} << dsh12);
    inc    = g_r & (st_r | pf_r[0]);

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          stat_nxt = 1'b0;
          case (pop_item.kind)
            K_ARITH: begin
              pwr_nxt   = 1'b0;
              op_nxt    = pop_item.op;
              x_nxt     = pop_item.opa;
              y_nxt     = pop_item.opb;
              state_nxt = S_START;
            end
            K_POWER: begin
              pwr_nxt   = 1'b1;
              base_nxt  = pop_item.opa;
              cnt_nxt   = pop_item.cnt;
              neg_nxt   = pop_item.neg;
              res_nxt   = FP_ONE;
              state_nxt = S_PWR;
            end
            default: begin
              res_nxt   = pop_item.dval;
              stat_nxt  = pop_item.dstat;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_PWR: begin
        if (cnt_r != '0) begin
          op_nxt    = OP_MUL;
          x_nxt     = res_r;
          y_nxt     = base_r;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_START;
        end else if (neg_r) begin
          // final reciprocal for a negative exponent
          op_nxt    = OP_DIV;
          x_nxt     = FP_ONE;
          y_nxt     = res_r;
          neg_nxt   = 1'b0;
          state_nxt = S_START;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_START: begin
        if (spc[32]) begin
          res_nxt   = spc[31:0];
          state_nxt = pwr_r ? S_PWR : S_DONE;
        end else begin
          case (op_r)
            OP_ADD, OP_SUB: state_nxt = S_ALIGN;
            OP_MUL:         state_nxt = S_MUL;
            default:        state_nxt = S_DIVN;
          endcase
        end
      end
      S_ALIGN: begin
        rm_nxt    = {1'b0, sig24(lop), 25'h0};
        sm_nxt    = (small0 >> dsh) | {49'h0, |(small0 & smask)};
        re_nxt    = $signed({4'h0, el});
        rs_nxt    = lop[31];
        sub_nxt   = lop[31] ^ sop[31];
        // sign of an exact zero sum
        zs_nxt    = x_r[31] & yb[31];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        rm_nxt    = sum;
        if (sum == 50'h0) rs_nxt = zs_r;
        state_nxt = S_NORM;
      end
      S_MUL: begin
        rm_nxt    = {prod, 2'b00};
        re_nxt    = $signed({4'h0, exp_eff(x_r)}) + $signed({4'h0, exp_eff(y_r)})
                    - 12'sd127;
        rs_nxt    = x_r[31] ^ y_r[31];
        state_nxt = S_NORM;
      end
      S_DIVN: begin
        drem_nxt  = {1'b0, sig24(x_r) << lza};
        dd_nxt    = sig24(y_r) << lzb;
        dq_nxt    = '0;
        dcnt_nxt  = '0;
        re_nxt    = $signed({4'h0, exp_eff(x_r)}) - $signed({7'h0, lza})
                    - $signed({4'h0, exp_eff(y_r)}) + $signed({7'h0, lzb}) + 12'sd127;
        rs_nxt    = x_r[31] ^ y_r[31];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        dq_nxt   = nq;
        drem_nxt = {diff[23:0], 1'b0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'(DIV_BITS - 1)) begin
          rm_nxt    = {1'b0, nq, |diff, 22'h0};
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        zf_nxt = (rm_r == 50'h0);
        if (rm_r[49]) begin
          rm_nxt = {1'b0, rm_r[49:1]} | {49'h0, rm_r[0]};
          re_nxt = re_r + 12'sd1;
        end else if (rm_r != 50'h0) begin
          rm_nxt = rm_r << lz;
          re_nxt = re_r - $signed({6'h0, lz});
        end
        state_nxt = S_DEN;
      end
      S_DEN: begin
        ovf_nxt = (re_r >= 12'sd255);
        if (re_r <= 12'sd0) begin
          // subnormal: shift right with sticky
          pe_nxt = 8'h0;
          pf_nxt = dm[47:25];
          g_nxt  = dm[24];
          st_nxt = (|dm[23:0]) | (|(rm_r & dmask));
        end else begin
          pe_nxt = re_r[7:0];
          pf_nxt = rm_r[47:25];
          g_nxt  = rm_r[24];
          st_nxt = |rm_r[23:0];
        end
        state_nxt = S_RND;
      end
      S_RND: begin
        if (zf_r) begin
          res_nxt = {rs_r, 31'h0};
        end else if (ovf_r) begin
          res_nxt = {rs_r, 8'hFF, 23'h0};
        end else begin
          // carry out of the fraction bumps the exponent field
          res_nxt = {rs_r, {pe_r, pf_r} + {30'h0, inc}};
        end
        state_nxt = pwr_r ? S_PWR : S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pwr_r      <= pwr_nxt;
    op_r       <= op_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    base_r     <= base_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    rs_r       <= rs_nxt;
    zs_r       <= zs_nxt;
    sub_r      <= sub_nxt;
    re_r       <= re_nxt;
    rm_r       <= rm_nxt;
    sm_r       <= sm_nxt;
    zf_r       <= zf_nxt;
    ovf_r      <= ovf_nxt;
    pe_r       <= pe_nxt;
    pf_r       <= pf_nxt;
    g_r        <= g_nxt;
    st_r       <= st_nxt;
    dq_r       <= dq_nxt;
    drem_r     <= drem_nxt;
    dd_r       <= dd_nxt;
    dcnt_r     <= dcnt_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
  end

endmodule

`default_nettype wire

@@ sv/float_calculator_alu_core.sv @@
// ----------------------------------------------------------------------------
// float_calculator_alu_core
// Power: one multiply per unit of |b|, plus a final reciprocal divide for a negative b.
// One item executes at a time; set by the shared multiply/divide sequencer.
// Up to two more items are taken into the queue while one executes.
// Synchronous active-low reset empties the queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module float_calculator_alu_core import fca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fca_in_if.sink     in_chan,
  fca_out_if.source  out_chan
);

  logic      push_valid, push_ready;
  fca_item_t push_item;
  logic      pop_valid, pop_ready;
  fca_item_t pop_item;

  fca_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  fca_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  fca_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

@@ sv/fca_checker.sv @@
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks of the calculator ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "float_calculator_alu_core_defines.svh"

module fca_checker import fca_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic        out_status
);

  localparam int PEND_W = $clog2(MAX_PEND + 1);

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              in_xfer, out_xfer;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `FCA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_result_value) && $stable(out_status), "result changed while stalled")
  `FCA_ASSERT(a_flag_zero, out_valid && out_status |-> out_result_value == 32'h0, "flagged result not zero")
  `FCA_ASSERT(a_no_orphan, out_valid |-> pend_r != '0, "result without a pending item")
  `FCA_ASSERT(a_pend_bound, pend_r <= PEND_W'(MAX_PEND), "too many items in flight")

endmodule

bind float_calculator_alu_core fca_checker u_fca_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_result_value (out_chan.result_value),
  .out_status       (out_chan.status)
);

`default_nettype wire
